FILE: hdl/utrbd_pkg.sv
// ----------------------------------------------------------------------------
// utrbd_pkg
// Shared constants and types of the transmit ring burst drain unit.
// ----------------------------------------------------------------------------
package utrbd_pkg;

  localparam int RING_DEPTH = 256;
  localparam int FIFO_DEPTH = 16;

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int REM_W  = $clog2(FIFO_DEPTH + 1);
  localparam int BYTE_W = 8;
  localparam int CALL_W = 9;
  localparam int FILL_W = 9;
  localparam int KIND_W = 2;

  localparam logic [CALL_W-1:0] CALL_MAX = '1;

  localparam logic CMD_WRITE      = 1'b0;
  localparam logic CMD_FIFO_EMPTY = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK   = 2'd0,
    KIND_SENT  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    logic wr;
    logic mark_empty;
    logic drain_start;
    logic drain_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic idle_mark;
    logic ring_empty;
    logic drain_last;
  } ctl_stat_t;

endpackage

FILE: hdl/utrbd_ram.sv
// ----------------------------------------------------------------------------
// utrbd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module utrbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/utrbd_ctrl.sv
// ----------------------------------------------------------------------------
// utrbd_ctrl
// Controller: accepts commands and sequences the burst drain.
// ----------------------------------------------------------------------------
module utrbd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_cmd,
  input  logic                 in_end_of_write,
  input  utrbd_pkg::ctl_stat_t stat,
  output utrbd_pkg::ctl_cmd_t  cmd,
  output logic                 busy
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == utrbd_pkg::CMD_WRITE) begin
            cmd.wr = 1'b1;
            if (in_end_of_write && stat.idle_mark) begin
              cmd.drain_start = 1'b1;
              state_nxt       = ST_DRAIN;
            end
          end else if (stat.ring_empty) begin
            cmd.mark_empty = 1'b1;
          end else begin
            cmd.drain_start = 1'b1;
            state_nxt       = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        cmd.drain_step = 1'b1;
        if (stat.drain_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/utrbd_dpath.sv
// ----------------------------------------------------------------------------
// utrbd_dpath
// Datapath: ring storage, pointers, counters and the registered result.
// ----------------------------------------------------------------------------
module utrbd_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  utrbd_pkg::ctl_cmd_t                   cmd,
  input  logic [utrbd_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic                                  in_end_of_write,
  output utrbd_pkg::ctl_stat_t                  stat,
  output logic                                  out_strobe,
  output logic [utrbd_pkg::KIND_W-1:0]          out_kind,
  output logic [utrbd_pkg::BYTE_W-1:0]          out_byte,
  output logic                                  out_accepted,
  output logic [utrbd_pkg::CALL_W-1:0]          out_call_total,
  output logic [utrbd_pkg::FILL_W-1:0]          out_fill_level,
  output logic                                  out_final_res
);

  localparam int IDX_W = utrbd_pkg::IDX_W;
  localparam int CNT_W = utrbd_pkg::CNT_W;
  localparam int REM_W = utrbd_pkg::REM_W;

  logic [IDX_W-1:0]             head_r, head_nxt;
  logic [IDX_W-1:0]             tail_r, tail_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [REM_W-1:0]             remain_r, remain_nxt;
  logic                         idle_r, idle_nxt;
  logic [utrbd_pkg::CALL_W-1:0] call_r, call_nxt, call_inc;

  logic                         strobe_r, strobe_nxt;
  utrbd_pkg::kind_t             kind_r, kind_nxt;
  logic                         acc_r, acc_nxt;
  logic [utrbd_pkg::CALL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]             fill_r, fill_nxt;
  logic                         final_r, final_nxt;

  logic                         ram_we, ram_re, full;
  logic [utrbd_pkg::BYTE_W-1:0] ram_rdata;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(utrbd_pkg::RING_DEPTH - 1)) ? '0 : IDX_W'(idx + 1'b1);
  endfunction

  assign full     = (count_r == CNT_W'(utrbd_pkg::RING_DEPTH));
  assign call_inc = (call_r == utrbd_pkg::CALL_MAX) ? call_r : call_r + 1'b1;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    remain_nxt = remain_r;
    idle_nxt   = idle_r;
    call_nxt   = call_r;
    strobe_nxt = 1'b0;
    kind_nxt   = kind_r;
    acc_nxt    = acc_r;
    total_nxt  = total_r;
    fill_nxt   = fill_r;
    final_nxt  = final_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    if (cmd.wr) begin
      if (!full) begin
        ram_we    = 1'b1;
        head_nxt  = idx_inc(head_r);
        count_nxt = count_r + 1'b1;
        call_nxt  = call_inc;
      end
      strobe_nxt = 1'b1;
      kind_nxt   = utrbd_pkg::KIND_ACK;
      acc_nxt    = !full;
      total_nxt  = call_nxt;
      fill_nxt   = count_nxt;
      final_nxt  = !(in_end_of_write && idle_r);
      if (in_end_of_write) begin
        call_nxt = '0;
      end
    end

    if (cmd.drain_start) begin
      idle_nxt = 1'b0;
      if (32'(count_nxt) > 32'(utrbd_pkg::FIFO_DEPTH)) begin
        remain_nxt = REM_W'(utrbd_pkg::FIFO_DEPTH);
      end else begin
        remain_nxt = REM_W'(count_nxt);
      end
    end

    if (cmd.mark_empty) begin
      idle_nxt   = 1'b1;
      strobe_nxt = 1'b1;
      kind_nxt   = utrbd_pkg::KIND_EMPTY;
      acc_nxt    = 1'b0;
      total_nxt  = '0;
      fill_nxt   = count_r;
      final_nxt  = 1'b1;
    end

    if (cmd.drain_step) begin
      ram_re     = 1'b1;
      tail_nxt   = idx_inc(tail_r);
      count_nxt  = count_r - 1'b1;
      remain_nxt = remain_r - 1'b1;
      strobe_nxt = 1'b1;
      kind_nxt   = utrbd_pkg::KIND_SENT;
      acc_nxt    = 1'b0;
      total_nxt  = '0;
      fill_nxt   = count_nxt;
      final_nxt  = (remain_r == REM_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      remain_r <= '0;
      idle_r   <= 1'b0;
      call_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      idle_r   <= idle_nxt;
      call_r   <= call_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    acc_r   <= acc_nxt;
    total_r <= total_nxt;
    fill_r  <= fill_nxt;
    final_r <= final_nxt;
  end

  utrbd_ram #(
    .WIDTH(utrbd_pkg::BYTE_W),
    .DEPTH(utrbd_pkg::RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head_r),
    .wdata(in_data_byte),
    .re   (ram_re),
    .raddr(tail_r),
    .rdata(ram_rdata)
  );

  assign stat.idle_mark  = idle_r;
  assign stat.ring_empty = (count_r == '0);
  assign stat.drain_last = (remain_r == REM_W'(1));

  assign out_strobe     = strobe_r;
  assign out_kind       = kind_r;
  assign out_byte       = (kind_r == utrbd_pkg::KIND_SENT) ? ram_rdata : '0;
  assign out_accepted   = acc_r;
  assign out_call_total = total_r;
  assign out_fill_level = utrbd_pkg::FILL_W'(fill_r);
  assign out_final_res  = final_r;

endmodule

FILE: hdl/uart_tx_ring_burst_drain_unit.sv
// ----------------------------------------------------------------------------
// uart_tx_ring_burst_drain_unit
// Transmit ring buffer that stores write bytes and drains them to a UART FIFO.
// ----------------------------------------------------------------------------
//  Channel  Handshake          Fields
//  in       start / busy       in_cmd, in_data_byte, in_end_of_write
//  out      out_strobe         out_kind, out_byte, out_accepted,
//                              out_call_total, out_fill_level, out_final_res
//
//  A write byte's acknowledgement follows in the next cycle.
//  A drain keeps busy high while it reads up to FIFO_DEPTH bytes, one ring RAM
//  read per byte, after the event or call-ending write that started it.
//  Reset is synchronous and needs no clearing pass over the ring RAM.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module uart_tx_ring_burst_drain_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [utrbd_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                         in_end_of_write,
  output logic                         out_strobe,
  output logic [utrbd_pkg::KIND_W-1:0] out_kind,
  output logic [utrbd_pkg::BYTE_W-1:0] out_byte,
  output logic                         out_accepted,
  output logic [utrbd_pkg::CALL_W-1:0] out_call_total,
  output logic [utrbd_pkg::FILL_W-1:0] out_fill_level,
  output logic                         out_final_res
);

  utrbd_pkg::ctl_cmd_t  cmd;
  utrbd_pkg::ctl_stat_t stat;

  utrbd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_cmd         (in_cmd),
    .in_end_of_write(in_end_of_write),
    .stat           (stat),
    .cmd            (cmd),
    .busy           (busy)
  );

  utrbd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_data_byte   (in_data_byte),
    .in_end_of_write(in_end_of_write),
    .stat           (stat),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_accepted   (out_accepted),
    .out_call_total (out_call_total),
    .out_fill_level (out_fill_level),
    .out_final_res  (out_final_res)
  );

endmodule

FILE: hdl/utrbd_checker.sv
// ----------------------------------------------------------------------------
// utrbd_checker
// Port-level checks of result ordering and busy behavior.
// ----------------------------------------------------------------------------
module utrbd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_cmd,
  input logic                         out_strobe,
  input logic [utrbd_pkg::KIND_W-1:0] out_kind,
  input logic [utrbd_pkg::FILL_W-1:0] out_fill_level,
  input logic                         out_final_res
);

  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == utrbd_pkg::CMD_WRITE)
    |=> out_strobe && (out_kind == utrbd_pkg::KIND_ACK))
    else $error("Write transfer was not acknowledged in the next cycle.");

  a_event_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == utrbd_pkg::CMD_FIFO_EMPTY)
    |=> (out_strobe && (out_kind == utrbd_pkg::KIND_EMPTY)) or
        (!out_strobe ##1 (out_strobe && (out_kind == utrbd_pkg::KIND_SENT))))
    else $error("FIFO-empty event did not start its results on time.");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == utrbd_pkg::KIND_EMPTY)
    |-> (out_fill_level == '0) && out_final_res)
    else $error("Empty drain result reports queued bytes or is not final.");

  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_final_res |=> out_strobe)
    else $error("Results of one transfer are not contiguous.");

  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_final_res |-> !busy)
    else $error("Unit still busy while its last result is shown.");

endmodule

bind uart_tx_ring_burst_drain_unit utrbd_checker u_utrbd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_cmd        (in_cmd),
  .out_strobe    (out_strobe),
  .out_kind      (out_kind),
  .out_fill_level(out_fill_level),
  .out_final_res (out_final_res)
);
